[rtl/scae_pkg.sv]
// ----------------------------------------------------------------------------
// scae_pkg
// Types, opcodes and constants shared by the stack-carry ALU execute pipeline.
// ----------------------------------------------------------------------------
package scae_pkg;

	localparam int DATA_W = 16;
	localparam int EXT_W = 32;
	localparam int DIV_BITS = 2;
	localparam int DIV_STAGES = EXT_W / DIV_BITS;

	localparam logic [7:0] OP_NOP  = 8'h00;
	localparam logic [7:0] OP_MOV  = 8'h01;
	localparam logic [7:0] OP_SWAP = 8'h02;
	localparam logic [7:0] OP_ADD  = 8'h20;
	localparam logic [7:0] OP_SUB  = 8'h21;
	localparam logic [7:0] OP_MUL  = 8'h22;
	localparam logic [7:0] OP_DIV  = 8'h23;
	localparam logic [7:0] OP_MOD  = 8'h24;
	localparam logic [7:0] OP_AND  = 8'h25;
	localparam logic [7:0] OP_XOR  = 8'h26;
	localparam logic [7:0] OP_OR   = 8'h27;
	localparam logic [7:0] OP_SHL  = 8'h28;
	localparam logic [7:0] OP_SHR  = 8'h29;
	localparam logic [7:0] OP_UMUL = 8'h30;
	localparam logic [7:0] OP_UDIV = 8'h31;
	localparam logic [7:0] OP_UMOD = 8'h32;
	localparam logic [7:0] OP_USHL = 8'h33;
	localparam logic [7:0] OP_USHR = 8'h34;
	localparam logic [7:0] OP_NOT  = 8'h40;
	localparam logic [7:0] OP_INC  = 8'h41;
	localparam logic [7:0] OP_DEC  = 8'h42;
	localparam logic [7:0] OP_CMP  = 8'h60;
	localparam logic [7:0] OP_JE   = 8'h70;
	localparam logic [7:0] OP_JNE  = 8'h71;
	localparam logic [7:0] OP_JLT  = 8'h72;
	localparam logic [7:0] OP_JLE  = 8'h73;
	localparam logic [7:0] OP_JGT  = 8'h74;
	localparam logic [7:0] OP_JGE  = 8'h75;
	localparam logic [7:0] OP_IDLE0 = 8'h80;
	localparam logic [7:0] OP_IDLE3 = 8'h83;

	localparam logic [2:0] AM_IMM16 = 3'd0;
	localparam logic [2:0] AM_IMM8  = 3'd1;
	localparam logic [2:0] AM_DIR16 = 3'd2;
	localparam logic [2:0] AM_DIR8  = 3'd3;
	localparam logic [2:0] AM_IND16 = 3'd4;
	localparam logic [2:0] AM_IND8  = 3'd5;

	localparam logic [2:0] SM_NONE = 3'd0;
	localparam logic [2:0] SM_POP  = 3'd1;
	localparam logic [2:0] SM_PUSH = 3'd2;
	localparam logic [2:0] SM_BOTH = 3'd3;

	localparam logic [1:0] WK_NONE = 2'd0;
	localparam logic [1:0] WK_WORD = 2'd1;
	localparam logic [1:0] WK_BYTE = 2'd2;

	localparam logic [2:0] FLT_OK    = 3'd0;
	localparam logic [2:0] FLT_OPC   = 3'd1;
	localparam logic [2:0] FLT_LEFT  = 3'd2;
	localparam logic [2:0] FLT_DIV0  = 3'd3;
	localparam logic [2:0] FLT_ADDR  = 3'd4;

	localparam logic [1:0] SEL_RES = 2'd0;
	localparam logic [1:0] SEL_QUO = 2'd1;
	localparam logic [1:0] SEL_REM = 2'd2;

	typedef struct packed {
		logic [2:0]        fault;
		logic              alu;
		logic [1:0]        wk;
		logic              pop;
		logic              push;
		logic [DATA_W-1:0] pd;
		logic              jump;
		logic [DATA_W-1:0] jtgt;
		logic [1:0]        sel;
		logic [EXT_W-1:0]  res;
		logic [EXT_W-1:0]  addend;
	} ctl_t;

endpackage

[rtl/scae_decode.sv]
// ----------------------------------------------------------------------------
// scae_decode
// First stage: decode, fault check, operand extension and all non-divide ops.
// ----------------------------------------------------------------------------
module scae_decode (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        vin,
	input  logic [7:0]                  mode,
	input  logic [2:0]                  stk_mode,
	input  logic                        lhs_sext,
	input  logic                        rhs_sext,
	input  logic [2:0]                  left_addressing,
	input  logic [2:0]                  right_addressing,
	input  logic [scae_pkg::DATA_W-1:0] lhs_word,
	input  logic [scae_pkg::DATA_W-1:0] rhs_word,
	input  logic [scae_pkg::DATA_W-1:0] stack_top,
	output logic                        v_s1,
	output scae_pkg::ctl_t              ctl_s1,
	output logic [2*scae_pkg::EXT_W-1:0] rq_s1,
	output logic [scae_pkg::EXT_W-1:0]  d_s1
);

	localparam int W = scae_pkg::DATA_W;
	localparam int X = scae_pkg::EXT_W;

	scae_pkg::ctl_t c;
	logic pop, push, nop, binop, unop, cmp, jmp, divop, modop, t;
	logic [X-1:0] a, b, r, stop_s, mul_r;
	logic [W-1:0] cw;
	logic [1:0] wk;
	logic big;

	always_comb begin
		pop = (stk_mode == scae_pkg::SM_POP) || (stk_mode == scae_pkg::SM_BOTH);
		push = (stk_mode == scae_pkg::SM_PUSH) || (stk_mode == scae_pkg::SM_BOTH);
		if ((left_addressing == scae_pkg::AM_DIR16) || (left_addressing == scae_pkg::AM_IND16))
			wk = scae_pkg::WK_WORD;
		else if ((left_addressing == scae_pkg::AM_DIR8) ||
			(left_addressing == scae_pkg::AM_IND8))
			wk = scae_pkg::WK_BYTE;
		else
			wk = scae_pkg::WK_NONE;
		nop = (mode == scae_pkg::OP_NOP) ||
			((mode >= scae_pkg::OP_IDLE0) && (mode <= scae_pkg::OP_IDLE3));
		binop = (mode == scae_pkg::OP_MOV) || (mode == scae_pkg::OP_SWAP) ||
			((mode >= scae_pkg::OP_ADD) && (mode <= scae_pkg::OP_SHR)) ||
			((mode >= scae_pkg::OP_UMUL) && (mode <= scae_pkg::OP_USHR));
		unop = (mode >= scae_pkg::OP_NOT) && (mode <= scae_pkg::OP_DEC);
		cmp = (mode == scae_pkg::OP_CMP);
		jmp = (mode >= scae_pkg::OP_JE) && (mode <= scae_pkg::OP_JGE);
		divop = (mode == scae_pkg::OP_DIV) || (mode == scae_pkg::OP_UDIV);
		modop = (mode == scae_pkg::OP_MOD) || (mode == scae_pkg::OP_UMOD);
		a = {{(X-W){lhs_sext & lhs_word[W-1]}}, lhs_word};
		b = {{(X-W){rhs_sext & rhs_word[W-1]}}, rhs_word};
		stop_s = {{(X-W){stack_top[W-1]}}, stack_top};
		big = (b[X-1:5] != '0);
		mul_r = a * b;
		cw = pop ? stack_top : '0;

		case (mode)
			scae_pkg::OP_JE:  t = (cw == '0);
			scae_pkg::OP_JNE: t = (cw != '0);
			scae_pkg::OP_JLT: t = cw[W-1];
			scae_pkg::OP_JLE: t = cw[W-1] || (cw == '0);
			scae_pkg::OP_JGT: t = !cw[W-1] && (cw != '0);
			default:          t = !cw[W-1];
		endcase

		case (mode)
			scae_pkg::OP_ADD:  r = a + b;
			scae_pkg::OP_SUB:  r = a - b;
			scae_pkg::OP_MUL,
			scae_pkg::OP_UMUL: r = mul_r;
			scae_pkg::OP_AND:  r = a & b;
			scae_pkg::OP_XOR:  r = a ^ b;
			scae_pkg::OP_OR:   r = a | b;
			scae_pkg::OP_SHL,
			scae_pkg::OP_USHL: r = big ? '0 : (a << b[4:0]);
			scae_pkg::OP_SHR,
			scae_pkg::OP_USHR: r = big ? '0 : (a >> b[4:0]);
			scae_pkg::OP_NOT:  r = ~{{(X-W){1'b0}}, lhs_word};
			scae_pkg::OP_INC:  r = {{(X-W){1'b0}}, lhs_word} + X'(1);
			scae_pkg::OP_DEC:  r = {{(X-W){1'b0}}, lhs_word} - X'(1);
			default:           r = b;
		endcase

		c = '0;
		c.sel = scae_pkg::SEL_RES;
		if (nop) begin
			c.fault = scae_pkg::FLT_OK;
		end else if (!binop && !unop && !cmp && !jmp) begin
			c.fault = scae_pkg::FLT_OPC;
		end else if ((left_addressing > scae_pkg::AM_IND8) ||
			((binop || cmp) && (right_addressing > scae_pkg::AM_IND8))) begin
			c.fault = scae_pkg::FLT_ADDR;
		end else if ((divop || modop) && (b == '0)) begin
			c.fault = scae_pkg::FLT_DIV0;
		end else if (binop && (wk == scae_pkg::WK_NONE)) begin
			c.fault = scae_pkg::FLT_LEFT;
		end else if (jmp) begin
			c.pop = pop;
			c.push = push;
			c.pd = push ? cw : '0;
			c.jump = t;
			c.jtgt = t ? lhs_word : '0;
		end else if (cmp) begin
			c.pop = pop;
			c.push = push;
			if (!push)
				c.pd = '0;
			else if (a < b)
				c.pd = '1;
			else if (a > b)
				c.pd = W'(1);
			else
				c.pd = '0;
		end else begin
			c.alu = 1'b1;
			c.pop = pop;
			c.push = push;
			c.wk = wk;
			c.res = r;
			if (divop)
				c.sel = scae_pkg::SEL_QUO;
			else if (modop)
				c.sel = scae_pkg::SEL_REM;
			if (pop)
				c.addend = unop ? stop_s : {{(X-W){1'b0}}, stack_top};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= vin;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= c;
			rq_s1 <= {{X{1'b0}}, a};
			d_s1 <= b;
		end
	end

endmodule

[rtl/scae_div_step.sv]
// ----------------------------------------------------------------------------
// scae_div_step
// One restoring-division stage: retires DIV_BITS quotient bits per cycle while adv is high.
// ----------------------------------------------------------------------------
module scae_div_step (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         vin,
	input  scae_pkg::ctl_t               ctl_in,
	input  logic [2*scae_pkg::EXT_W-1:0] rq_in,
	input  logic [scae_pkg::EXT_W-1:0]   d_in,
	output logic                         v_q,
	output scae_pkg::ctl_t               ctl_q,
	output logic [2*scae_pkg::EXT_W-1:0] rq_q,
	output logic [scae_pkg::EXT_W-1:0]   d_q
);

	localparam int X = scae_pkg::EXT_W;

	logic [2*X-1:0] rq;
	logic [2*X:0]   sh;
	logic [X:0]     diff;

	always_comb begin
		rq = rq_in;
		sh = '0;
		diff = '0;
		for (int i = 0; i < scae_pkg::DIV_BITS; i++) begin
			sh = {rq, 1'b0};
			diff = sh[2*X:X] - {1'b0, d_in};
			if (!diff[X])
				rq = {diff[X-1:0], sh[X-1:1], 1'b1};
			else
				rq = sh[2*X-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= 1'b0;
		else if (adv)
			v_q <= vin;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_q <= ctl_in;
			rq_q <= rq;
			d_q <= d_in;
		end
	end

endmodule

[rtl/stack_carry_alu_execute.sv]
// ----------------------------------------------------------------------------
// stack_carry_alu_execute
// Execute stage of a 16-bit stack-carry CPU, as a fixed-depth pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   One instruction transfers on cmd_valid & cmd_ready with its opcode, stack
//   mode, sign flags, addressing modes, operand values and stack top. Each
//   instruction gives exactly one result transfer on res_valid & res_ready.
//   The pipeline has a decode stage, sixteen restoring-division stages of
//   two quotient bits each, and an output stage that picks quotient,
//   remainder or ALU result and adds the popped carry.
//   Every instruction travels the full depth, so results leave in order.
//   Throughput is one per cycle unless frozen; the divider stages set depth.
//   When the receiver holds res_ready low with a result waiting, the whole
//   pipeline freezes and cmd_ready drops; nothing is lost or repeated.
//   Reset clears all valid bits; payload registers are not reset.
//   Faults zero every other result field.
// ----------------------------------------------------------------------------
module stack_carry_alu_execute (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  logic [7:0]                  mode,
	input  logic [2:0]                  stk_mode,
	input  logic                        lhs_sext,
	input  logic                        rhs_sext,
	input  logic [2:0]                  left_addressing,
	input  logic [2:0]                  right_addressing,
	input  logic [scae_pkg::DATA_W-1:0] lhs_word,
	input  logic [scae_pkg::DATA_W-1:0] rhs_word,
	input  logic [scae_pkg::DATA_W-1:0] stack_top,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [1:0]                  write_kind,
	output logic [scae_pkg::DATA_W-1:0] write_data,
	output logic                        push_valid,
	output logic [scae_pkg::DATA_W-1:0] push_data,
	output logic                        pop_taken,
	output logic                        jump_taken,
	output logic [scae_pkg::DATA_W-1:0] jump_target,
	output logic [2:0]                  fault
);

	localparam int X = scae_pkg::EXT_W;
	localparam int N = scae_pkg::DIV_STAGES;
	localparam int W = scae_pkg::DATA_W;

	logic adv;
	logic           v_p  [N+1];
	scae_pkg::ctl_t c_p  [N+1];
	logic [2*X-1:0] rq_p [N+1];
	logic [X-1:0]   d_p  [N+1];

	scae_pkg::ctl_t cf;
	logic [X-1:0] base, r;

	assign adv = !res_valid || res_ready;
	assign cmd_ready = adv;

	scae_decode u_dec (
		.clk(clk), .arst_n(arst_n), .adv(adv), .vin(cmd_valid && cmd_ready),
		.mode(mode), .stk_mode(stk_mode), .lhs_sext(lhs_sext),
		.rhs_sext(rhs_sext), .left_addressing(left_addressing),
		.right_addressing(right_addressing), .lhs_word(lhs_word),
		.rhs_word(rhs_word), .stack_top(stack_top),
		.v_s1(v_p[0]), .ctl_s1(c_p[0]), .rq_s1(rq_p[0]), .d_s1(d_p[0])
	);

	for (genvar g = 0; g < N; g++) begin : g_div
		scae_div_step u_step (
			.clk(clk), .arst_n(arst_n), .adv(adv), .vin(v_p[g]),
			.ctl_in(c_p[g]), .rq_in(rq_p[g]), .d_in(d_p[g]),
			.v_q(v_p[g+1]), .ctl_q(c_p[g+1]), .rq_q(rq_p[g+1]), .d_q(d_p[g+1])
		);
	end

	always_comb begin
		cf = c_p[N];
		case (cf.sel)
			scae_pkg::SEL_QUO: base = rq_p[N][X-1:0];
			scae_pkg::SEL_REM: base = rq_p[N][2*X-1:X];
			default:           base = cf.res;
		endcase
		r = base + cf.addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid <= 1'b0;
		else if (adv)
			res_valid <= v_p[N];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fault <= cf.fault;
			pop_taken <= cf.pop;
			push_valid <= cf.push;
			jump_taken <= cf.jump;
			jump_target <= cf.jtgt;
			write_kind <= cf.wk;
			if (cf.alu) begin
				write_data <= (cf.wk != scae_pkg::WK_NONE) ? r[W-1:0] : '0;
				push_data <= cf.push ? r[2*W-1:W] : '0;
			end else begin
				write_data <= '0;
				push_data <= cf.pd;
			end
		end
	end

	a_fault_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && fault != scae_pkg::FLT_OK) |->
		(write_kind == scae_pkg::WK_NONE && !push_valid && !pop_taken && !jump_taken))
		else $error("fault result carries side effects");

	a_jump_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && jump_taken) |-> (write_kind == scae_pkg::WK_NONE))
		else $error("jump with a write");

	a_push_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !push_valid) |-> (push_data == '0))
		else $error("push data without push");

endmodule
